/* rtl/biou_pkg.sv */
// Shared constants for the box IoU cost pipeline.
package biou_pkg;

  // Default field and result widths.
  localparam int unsigned COORD_BITS_DEFAULT     = 16;
  localparam int unsigned COST_FRAC_BITS_DEFAULT = 16;

  // Stages ahead of the divider: corners, overlap, products, union.
  localparam int unsigned FRONT_STAGES = 4;

endpackage : biou_pkg

/* rtl/biou_if.sv */
// Valid/ready channel interfaces for box pairs and cost words.

interface biou_pair_if
  import biou_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_center_x;
  logic signed [COORD_BITS-1:0] a_center_y;
  logic        [COORD_BITS-1:0] a_width;
  logic        [COORD_BITS-1:0] a_height;
  logic signed [COORD_BITS-1:0] b_center_x;
  logic signed [COORD_BITS-1:0] b_center_y;
  logic        [COORD_BITS-1:0] b_width;
  logic        [COORD_BITS-1:0] b_height;

  modport source (
    output valid, a_center_x, a_center_y, a_width, a_height,
           b_center_x, b_center_y, b_width, b_height,
    input  ready
  );

  modport sink (
    input  valid, a_center_x, a_center_y, a_width, a_height,
           b_center_x, b_center_y, b_width, b_height,
    output ready
  );
endinterface : biou_pair_if

interface biou_cost_if
  import biou_pkg::*;
#(
  parameter int unsigned COST_FRAC_BITS = COST_FRAC_BITS_DEFAULT
);
  logic                    valid;
  logic                    ready;
  logic [COST_FRAC_BITS:0] cost;

  modport source (
    output valid, cost,
    input  ready
  );

  modport sink (
    input  valid, cost,
    output ready
  );
endinterface : biou_cost_if

/* rtl/bbox_iou_cost.sv */
// The pair passes COST_FRAC_BITS + 6 register stages, the first loaded at the accepting
// edge; the cost word is valid while the pair sits in the last of them.
// Throughput: one word per cycle while the output is ready; every stage holds one pair,
// the divider retires one quotient bit per stage so it never blocks the stream.
// A stalled output only holds back the stages behind it; empty stages still fill.
// Reset clears the stage valid bits only; data registers are not reset.
module bbox_iou_cost
  import biou_pkg::*;
#(
  parameter int unsigned COORD_BITS     = COORD_BITS_DEFAULT,
  parameter int unsigned COST_FRAC_BITS = COST_FRAC_BITS_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  biou_pair_if.sink    in_i,
  biou_cost_if.source  out_o
);

  // Widths derived from the coordinate width.
  localparam int unsigned CW     = COORD_BITS + 2;      // doubled corner, signed
  localparam int unsigned DW     = COORD_BITS + 3;      // corner difference, signed
  localparam int unsigned IW     = COORD_BITS + 1;      // positive overlap extent
  localparam int unsigned AREA_W = 2 * COORD_BITS;      // one box area
  localparam int unsigned SUM_W  = AREA_W + 1;          // sum of both areas
  localparam int unsigned INT_W  = 2 * IW;              // intersection, x4 units
  localparam int unsigned DEN_W  = SUM_W + 2;           // union, x4 units
  localparam int unsigned Q_W    = COST_FRAC_BITS + 1;  // quotient incl. integer bit

  // Stage map: front stages, divider set-up, one stage per fraction bit, output.
  localparam int unsigned DIV0 = FRONT_STAGES;
  localparam int unsigned NS   = FRONT_STAGES + COST_FRAC_BITS + 2;

  localparam logic [Q_W-1:0] COST_ONE = {1'b1, {COST_FRAC_BITS{1'b0}}};

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // Stage k takes a new word when it is empty or its own word moves on.
  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: corners in doubled units, 2*centre -/+ size.
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] ax1_d, ax2_d, ay1_d, ay2_d, bx1_d, bx2_d, by1_d, by2_d;
  logic signed [CW-1:0] s1_ax1_q, s1_ax2_q, s1_ay1_q, s1_ay2_q;
  logic signed [CW-1:0] s1_bx1_q, s1_bx2_q, s1_by1_q, s1_by2_q;
  logic [COORD_BITS-1:0] s1_aw_q, s1_ah_q, s1_bw_q, s1_bh_q;

  function automatic logic signed [CW-1:0] dbl(input logic signed [COORD_BITS-1:0] c);
    return $signed({c[COORD_BITS-1], c, 1'b0});
  endfunction

  function automatic logic signed [CW-1:0] uext(input logic [COORD_BITS-1:0] s);
    return $signed({2'b00, s});
  endfunction

  always_comb begin
    ax1_d = dbl(in_i.a_center_x) - uext(in_i.a_width);
    ax2_d = dbl(in_i.a_center_x) + uext(in_i.a_width);
    ay1_d = dbl(in_i.a_center_y) - uext(in_i.a_height);
    ay2_d = dbl(in_i.a_center_y) + uext(in_i.a_height);
    bx1_d = dbl(in_i.b_center_x) - uext(in_i.b_width);
    bx2_d = dbl(in_i.b_center_x) + uext(in_i.b_width);
    by1_d = dbl(in_i.b_center_y) - uext(in_i.b_height);
    by2_d = dbl(in_i.b_center_y) + uext(in_i.b_height);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_ax1_q <= ax1_d;
      s1_ax2_q <= ax2_d;
      s1_ay1_q <= ay1_d;
      s1_ay2_q <= ay2_d;
      s1_bx1_q <= bx1_d;
      s1_bx2_q <= bx2_d;
      s1_by1_q <= by1_d;
      s1_by2_q <= by2_d;
      s1_aw_q  <= in_i.a_width;
      s1_ah_q  <= in_i.a_height;
      s1_bw_q  <= in_i.b_width;
      s1_bh_q  <= in_i.b_height;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: overlap extents and both box areas (areas are x1 units here).
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] xmin_hi, xmax_lo, ymin_hi, ymax_lo;
  logic signed [DW-1:0] iw_d, ih_d;
  logic                 ovl_d;
  logic [IW-1:0]        s2_iw_q, s2_ih_q;
  logic                 s2_ovl_q;
  logic [AREA_W-1:0]    s2_area_a_q, s2_area_b_q;

  always_comb begin
    xmin_hi = (s1_ax2_q < s1_bx2_q) ? s1_ax2_q : s1_bx2_q;
    xmax_lo = (s1_ax1_q > s1_bx1_q) ? s1_ax1_q : s1_bx1_q;
    ymin_hi = (s1_ay2_q < s1_by2_q) ? s1_ay2_q : s1_by2_q;
    ymax_lo = (s1_ay1_q > s1_by1_q) ? s1_ay1_q : s1_by1_q;
    iw_d    = $signed({xmin_hi[CW-1], xmin_hi}) - $signed({xmax_lo[CW-1], xmax_lo});
    ih_d    = $signed({ymin_hi[CW-1], ymin_hi}) - $signed({ymax_lo[CW-1], ymax_lo});
    // Both extents strictly positive, else the boxes do not overlap.
    ovl_d   = !iw_d[DW-1] && (|iw_d) && !ih_d[DW-1] && (|ih_d);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_iw_q     <= iw_d[IW-1:0];
      s2_ih_q     <= ih_d[IW-1:0];
      s2_ovl_q    <= ovl_d;
      s2_area_a_q <= AREA_W'(s1_aw_q) * AREA_W'(s1_ah_q);
      s2_area_b_q <= AREA_W'(s1_bw_q) * AREA_W'(s1_bh_q);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: intersection (x4 units) and area sum.
  // ---------------------------------------------------------------------
  logic [INT_W-1:0] s3_inter_q;
  logic [SUM_W-1:0] s3_sum_q;
  logic             s3_ovl_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_inter_q <= INT_W'(s2_iw_q) * INT_W'(s2_ih_q);
      s3_sum_q   <= SUM_W'(s2_area_a_q) + SUM_W'(s2_area_b_q);
      s3_ovl_q   <= s2_ovl_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: union = 4*(area A + area B) - intersection, plus empty guard.
  // ---------------------------------------------------------------------
  logic [DEN_W-1:0] union4_d;
  logic [DEN_W-1:0] inter_ext;
  logic [DEN_W-1:0] s4_den_q;
  logic [DEN_W-1:0] s4_num_q;
  logic             s4_empty_q;

  assign union4_d  = {s3_sum_q, 2'b00};
  assign inter_ext = DEN_W'(s3_inter_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_den_q   <= union4_d - inter_ext;
      s4_num_q   <= inter_ext;
      s4_empty_q <= !s3_ovl_q || (union4_d <= inter_ext);
    end
  end

  // ---------------------------------------------------------------------
  // Divider: restoring, one quotient bit per stage. The set-up stage takes
  // the integer bit; clamping the numerator to the union leaves a zero
  // remainder there, so the clamp folds into that bit.
  // ---------------------------------------------------------------------
  logic [DEN_W-1:0] dv_r_q     [COST_FRAC_BITS+1];
  logic [DEN_W-1:0] dv_den_q   [COST_FRAC_BITS+1];
  logic [Q_W-1:0]   dv_q_q     [COST_FRAC_BITS+1];
  logic             dv_empty_q [COST_FRAC_BITS+1];

  logic dv0_ge;
  assign dv0_ge = (s4_num_q >= s4_den_q);

  always_ff @(posedge clk_i) begin
    if (en[DIV0]) begin
      dv_r_q[0]     <= dv0_ge ? '0 : s4_num_q;
      dv_den_q[0]   <= s4_den_q;
      dv_q_q[0]     <= Q_W'(dv0_ge);
      dv_empty_q[0] <= s4_empty_q;
    end
  end

  for (genvar j = 1; j <= COST_FRAC_BITS; j++) begin : g_div
    logic [DEN_W:0] r2;
    logic           ge;

    assign r2 = {dv_r_q[j-1], 1'b0};
    assign ge = (r2 >= {1'b0, dv_den_q[j-1]});

    always_ff @(posedge clk_i) begin
      if (en[DIV0+j]) begin
        dv_r_q[j]     <= ge ? DEN_W'(r2 - {1'b0, dv_den_q[j-1]}) : r2[DEN_W-1:0];
        dv_den_q[j]   <= dv_den_q[j-1];
        dv_q_q[j]     <= {dv_q_q[j-1][Q_W-2:0], ge};
        dv_empty_q[j] <= dv_empty_q[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: cost = 1.0 - IoU, or 1.0 for no overlap.
  // ---------------------------------------------------------------------
  logic [Q_W-1:0] cost_q;

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      cost_q <= dv_empty_q[COST_FRAC_BITS] ? COST_ONE
                                           : COST_ONE - dv_q_q[COST_FRAC_BITS];
    end
  end

  assign out_o.valid = v_q[NS-1];
  assign out_o.cost  = cost_q;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_empty_front_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> in_i.ready)
    else $error("front stage empty but input not ready");

  a_union_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[DIV0] && !dv_empty_q[0]) |-> (dv_den_q[0] != '0))
    else $error("divider started with zero union");

  a_rem_below_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NS-2] && !dv_empty_q[COST_FRAC_BITS]) |->
      (dv_r_q[COST_FRAC_BITS] < dv_den_q[COST_FRAC_BITS]))
    else $error("divider remainder not below union");

  a_cost_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.cost <= COST_ONE))
    else $error("cost above 1.0");

endmodule : bbox_iou_cost
